FILE: design/hsb_pkg.sv
// hsb_pkg: shared types, constants and the channel rounding function
// for the hue/saturation/brightness to rgb converter
// no dependencies
package hsb_pkg;

	localparam int unsigned NUM_W = 47;

	localparam logic [15:0] ONE_Q15   = 16'd32768;
	localparam logic [16:0] ONE_Q16   = 17'h10000;
	localparam logic [31:0] ONE_Q31   = 32'h8000_0000;
	localparam logic [7:0]  ALPHA_MAX = 8'hFF;
	localparam logic [7:0]  CHAN_MAX  = 8'hFF;

	typedef enum logic [2:0] {
		SEC_RED_YEL = 3'd0,
		SEC_YEL_GRN = 3'd1,
		SEC_GRN_CYN = 3'd2,
		SEC_CYN_BLU = 3'd3,
		SEC_BLU_MAG = 3'd4,
		SEC_MAG_RED = 3'd5
	} sector_t;

	// exact channel numerators over 2^46 plus the sector that orders them
	typedef struct packed {
		logic             valid;
		sector_t          sector;
		logic [NUM_W-1:0] nv;
		logic [NUM_W-1:0] np;
		logic [NUM_W-1:0] nq;
		logic [NUM_W-1:0] nt;
	} term_t;

	// floor(num * 255 / 2^46 + 1/2), clamped to 255
	function automatic logic [7:0] round_chan(input logic [NUM_W-1:0] num);
		logic [55:0] prod;
		logic [55:0] sum;
		logic [9:0]  v;
		prod = {1'b0, num, 8'b0} - {9'b0, num};
		sum  = prod + (56'd1 << 45);
		v    = sum[55:46];
		if (v > {2'b00, CHAN_MAX}) begin
			round_chan = CHAN_MAX;
		end else begin
			round_chan = v[7:0];
		end
	endfunction

endpackage

FILE: design/hsb_term_pipe.sv
// hsb_term_pipe: three stage pipeline forming the exact p, q, t and v numerators
// depends on hsb_pkg
module hsb_term_pipe (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic [15:0]    hue_frac,
	input  logic [15:0]    sat_level,
	input  logic [15:0]    bright_level,
	output hsb_pkg::term_t term
);

	// stage 1: clamp, hue times six
	logic             v_s1;
	hsb_pkg::sector_t sector_s1;
	logic [15:0]      f_s1;
	logic [15:0]      s_s1;
	logic [15:0]      b_s1;

	// stage 2: products with saturation
	logic             v_s2;
	hsb_pkg::sector_t sector_s2;
	logic [15:0]      b_s2;
	logic [31:0]      sf_s2;
	logic [31:0]      sg_s2;
	logic [31:0]      bs_s2;

	// stage 3: numerators over 2^46
	logic                      v_s3;
	hsb_pkg::sector_t          sector_s3;
	logic [hsb_pkg::NUM_W-1:0] nv_s3;
	logic [hsb_pkg::NUM_W-1:0] np_s3;
	logic [hsb_pkg::NUM_W-1:0] nq_s3;
	logic [hsb_pkg::NUM_W-1:0] nt_s3;

	logic [18:0] h6;
	logic [15:0] s_clamp;
	logic [15:0] b_clamp;
	logic [16:0] omf;
	logic [32:0] sg_full;
	logic [31:0] q_fac;
	logic [31:0] t_fac;
	logic [47:0] nq_full;
	logic [47:0] nt_full;

	always_comb begin
		h6      = {1'b0, hue_frac, 2'b00} + {2'b00, hue_frac, 1'b0};
		s_clamp = (sat_level > hsb_pkg::ONE_Q15) ? hsb_pkg::ONE_Q15 : sat_level;
		b_clamp = (bright_level > hsb_pkg::ONE_Q15) ? hsb_pkg::ONE_Q15 : bright_level;
		omf     = hsb_pkg::ONE_Q16 - {1'b0, f_s1};
		sg_full = s_s1 * omf;
		q_fac   = hsb_pkg::ONE_Q31 - sf_s2;
		t_fac   = hsb_pkg::ONE_Q31 - sg_s2;
		nq_full = b_s2 * q_fac;
		nt_full = b_s2 * t_fac;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		sector_s1 <= hsb_pkg::sector_t'(h6[18:16]);
		f_s1      <= h6[15:0];
		s_s1      <= s_clamp;
		b_s1      <= b_clamp;

		sector_s2 <= sector_s1;
		b_s2      <= b_s1;
		sf_s2     <= s_s1 * f_s1;
		sg_s2     <= sg_full[31:0];
		bs_s2     <= b_s1 * (hsb_pkg::ONE_Q15 - s_s1);

		sector_s3 <= sector_s2;
		nv_s3     <= {b_s2, 31'b0};
		np_s3     <= {bs_s2[30:0], 16'b0};
		nq_s3     <= nq_full[hsb_pkg::NUM_W-1:0];
		nt_s3     <= nt_full[hsb_pkg::NUM_W-1:0];
	end

	always_comb begin
		term.valid  = v_s3;
		term.sector = sector_s3;
		term.nv     = nv_s3;
		term.np     = np_s3;
		term.nq     = nq_s3;
		term.nt     = nt_s3;
	end

endmodule

FILE: design/hsb_round_pipe.sv
// hsb_round_pipe: rounding stage and sector channel select with output register
// depends on hsb_pkg
module hsb_round_pipe (
	input  logic           clk,
	input  logic           arst_n,
	input  hsb_pkg::term_t term,
	output logic           done,
	output logic [7:0]     red_out,
	output logic [7:0]     green_out,
	output logic [7:0]     blue_out,
	output logic [31:0]    argb_word
);

	logic             v_s4;
	hsb_pkg::sector_t sector_s4;
	logic [7:0]       cv_s4;
	logic [7:0]       cp_s4;
	logic [7:0]       cq_s4;
	logic [7:0]       ct_s4;

	logic             v_s5;
	logic [7:0]       r_s5;
	logic [7:0]       g_s5;
	logic [7:0]       b_s5;

	logic [7:0] r_sel;
	logic [7:0] g_sel;
	logic [7:0] b_sel;

	always_comb begin
		case (sector_s4)
			hsb_pkg::SEC_RED_YEL: begin
				r_sel = cv_s4; g_sel = ct_s4; b_sel = cp_s4;
			end
			hsb_pkg::SEC_YEL_GRN: begin
				r_sel = cq_s4; g_sel = cv_s4; b_sel = cp_s4;
			end
			hsb_pkg::SEC_GRN_CYN: begin
				r_sel = cp_s4; g_sel = cv_s4; b_sel = ct_s4;
			end
			hsb_pkg::SEC_CYN_BLU: begin
				r_sel = cp_s4; g_sel = cq_s4; b_sel = cv_s4;
			end
			hsb_pkg::SEC_BLU_MAG: begin
				r_sel = ct_s4; g_sel = cp_s4; b_sel = cv_s4;
			end
			default: begin
				r_sel = cv_s4; g_sel = cp_s4; b_sel = cq_s4;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s4 <= term.valid;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		sector_s4 <= term.sector;
		cv_s4     <= hsb_pkg::round_chan(term.nv);
		cp_s4     <= hsb_pkg::round_chan(term.np);
		cq_s4     <= hsb_pkg::round_chan(term.nq);
		ct_s4     <= hsb_pkg::round_chan(term.nt);

		r_s5 <= r_sel;
		g_s5 <= g_sel;
		b_s5 <= b_sel;
	end

	assign done      = v_s5;
	assign red_out   = r_s5;
	assign green_out = g_s5;
	assign blue_out  = b_s5;
	assign argb_word = {hsb_pkg::ALPHA_MAX, r_s5, g_s5, b_s5};

endmodule

FILE: design/hsb_to_rgb_converter.sv
// hsb_to_rgb_converter: top level, hue/saturation/brightness to rgb and argb
// depends on hsb_pkg, hsb_term_pipe, hsb_round_pipe
//
// channel   direction  handshake            payload
// command   in         start (busy low)     hue_frac, sat_level, bright_level
// result    out        done, one cycle      red_out, green_out, blue_out, argb_word
//
// one item per clock; each item gives one result, registered through the stages below
// stages: clamp and hue*6, saturation products, brightness products, rounding, select
// the 16x32 brightness multiply in the third stage sets the clock
// busy never rises, the receiver takes every result as it appears
// reset clears the valid bits only; items in flight are dropped
module hsb_to_rgb_converter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [15:0] hue_frac,
	input  logic [15:0] sat_level,
	input  logic [15:0] bright_level,
	output logic        done,
	output logic [7:0]  red_out,
	output logic [7:0]  green_out,
	output logic [7:0]  blue_out,
	output logic [31:0] argb_word
);

	hsb_pkg::term_t term;
	logic           accept;

	assign busy   = 1'b0;
	assign accept = start & ~busy;

	hsb_term_pipe u_term (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (accept),
		.hue_frac     (hue_frac),
		.sat_level    (sat_level),
		.bright_level (bright_level),
		.term         (term)
	);

	hsb_round_pipe u_round (
		.clk       (clk),
		.arst_n    (arst_n),
		.term      (term),
		.done      (done),
		.red_out   (red_out),
		.green_out (green_out),
		.blue_out  (blue_out),
		.argb_word (argb_word)
	);

endmodule

FILE: design/hsb_checker.sv
// hsb_checker: port level assertions for the converter, bound to the top level
// depends on hsb_to_rgb_converter ports only
module hsb_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic [15:0] sat_level,
	input logic        done,
	input logic [7:0]  red_out,
	input logic [7:0]  green_out,
	input logic [7:0]  blue_out,
	input logic [31:0] argb_word
);

	// every item taken comes out as a done pulse
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##5 done)
		else $error("item not delivered after five cycles");

	// no result without a matching item taken earlier
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 5))
		else $error("result without matching item");

	// zero saturation gives grey
	a_grey: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(sat_level == 16'd0, 5)) |-> (red_out == green_out && green_out == blue_out))
		else $error("zero saturation not grey");

	// packed word agrees with the channel outputs
	a_argb: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (argb_word[31:24] == 8'hFF && argb_word[23:16] == red_out &&
			argb_word[15:8] == green_out && argb_word[7:0] == blue_out))
		else $error("argb word mismatch");

endmodule

bind hsb_to_rgb_converter hsb_checker u_hsb_checker (.*);
